// ===== design/hbte_pkg.sv =====
// hbte_pkg: constants and codes for the HTTP body text extractor.
// No dependencies; imported by http_body_text_extractor.
`timescale 1ns / 1ps

package hbte_pkg;

    // Clamp limits for the configuration registers
    localparam int MAX_LINE_LIMIT = 128;
    localparam int MAX_LINE_WIDTH = 1024;

    // Register field widths
    localparam int WIDTH_W = 11;
    localparam int LIMIT_W = 8;
    localparam int CFG_W   = 11;

    // Register indexes
    typedef enum logic [0:0] {
        REG_LINE_WIDTH = 1'b0,
        REG_LINE_LIMIT = 1'b1
    } reg_index_t;

    // Input item kinds
    typedef enum logic [0:0] {
        KIND_BYTE = 1'b0,
        KIND_END  = 1'b1
    } item_kind_t;

    // Character codes
    localparam logic [7:0] CH_LT        = 8'h3C;
    localparam logic [7:0] CH_GT        = 8'h3E;
    localparam logic [7:0] CH_CR        = 8'h0D;
    localparam logic [7:0] CH_LF        = 8'h0A;
    localparam logic [7:0] CH_PRINT_LO  = 8'd32;
    localparam logic [7:0] CH_PRINT_END = 8'd127;

    // Register reset values
    localparam logic [WIDTH_W-1:0] LINE_WIDTH_RESET = 11'd780;
    localparam logic [LIMIT_W-1:0] LINE_LIMIT_RESET = 8'd70;

endpackage

// ===== design/http_body_text_extractor.sv =====
// http_body_text_extractor: strips HTTP headers and markup from a response
// byte stream and emits positioned text characters. Depends on hbte_pkg.
`timescale 1ns / 1ps

// One byte item per cycle in unless stalled, at most one text item out, held in a register.
// Each accepted byte updates the parse state (header/body, tag, line and
// column counters) in the same cycle and, if it produces text, loads the
// single output register. The input side keeps accepting while the output
// register is empty or being drained, so full rate is 1 item per clock;
// throughput drops only when the consumer holds m_tready low with a result
// pending. The header section is skipped through the first empty line (CR
// alone counts as empty). Body bytes inside <...> are dropped, as are CR and
// non-printable bytes. LF closes a line and emits an end-of-line item with
// the line length. Characters beyond line_width are dropped; once line_limit
// lines are done every byte is ignored until an end-of-response item, which
// flushes a partial line and restarts parsing. The user must write registers
// only while idle, not enforced by the block; they persist across responses.
module http_body_text_extractor
    import hbte_pkg::*;
(
    input  logic               aclk,
    input  logic               aresetn,
    // configuration write channel
    input  logic               cfg_valid,
    output logic               cfg_ready,
    input  logic [0:0]         cfg_index,
    input  logic [CFG_W-1:0]   cfg_data,
    // input stream
    input  logic               s_tvalid,
    output logic               s_tready,
    input  logic [7:0]         s_tdata,   // [7:0] data_byte
    input  logic [0:0]         s_tuser,   // [0] kind
    // result stream
    output logic               m_tvalid,
    input  logic               m_tready,
    output logic [31:0]        m_tdata,   // [6:0] text_char, [13:7] line_number,
                                          // [24:14] column, [31:25] zero
    output logic [0:0]         m_tuser    // [0] end_of_line
);

    // configuration
    logic [WIDTH_W-1:0] line_width_reg;
    logic [LIMIT_W-1:0] line_limit_reg;

    // parse state
    logic               in_body_reg, in_body_next;
    logic               hdr_empty_reg, hdr_empty_next;
    logic               in_tag_reg, in_tag_next;
    logic [LIMIT_W-1:0] lines_done_reg, lines_done_next;
    logic [WIDTH_W-1:0] column_reg, column_next;

    // result register
    logic               out_valid_reg;
    logic               out_eol_reg, out_eol_next;
    logic [6:0]         out_char_reg, out_char_next;
    logic [6:0]         out_line_reg, out_line_next;
    logic [WIDTH_W-1:0] out_col_reg, out_col_next;
    logic               emit;

    logic               s_accept;
    logic [WIDTH_W-1:0] eff_width;
    logic [LIMIT_W-1:0] eff_limit;
    logic               at_limit;
    logic [7:0]         c;

    assign cfg_ready = 1'b1;
    assign s_tready  = !out_valid_reg || m_tready;
    assign s_accept  = s_tvalid && s_tready;
    assign c         = s_tdata;

    assign eff_width = (line_width_reg > WIDTH_W'(MAX_LINE_WIDTH))
                       ? WIDTH_W'(MAX_LINE_WIDTH) : line_width_reg;
    assign eff_limit = (line_limit_reg > LIMIT_W'(MAX_LINE_LIMIT))
                       ? LIMIT_W'(MAX_LINE_LIMIT) : line_limit_reg;
    assign at_limit  = lines_done_reg >= eff_limit;

    // per-item parse step
    always_comb begin
        in_body_next    = in_body_reg;
        hdr_empty_next  = hdr_empty_reg;
        in_tag_next     = in_tag_reg;
        lines_done_next = lines_done_reg;
        column_next     = column_reg;
        emit            = 1'b0;
        out_eol_next    = 1'b0;
        out_char_next   = 7'd0;
        out_line_next   = lines_done_reg[6:0];
        out_col_next    = column_reg;

        if (item_kind_t'(s_tuser) == KIND_END) begin
            // flush partial line, then restart
            if (column_reg != '0 && !at_limit) begin
                emit         = 1'b1;
                out_eol_next = 1'b1;
            end
            in_body_next    = 1'b0;
            hdr_empty_next  = 1'b1;
            in_tag_next     = 1'b0;
            lines_done_next = '0;
            column_next     = '0;
        end else if (at_limit) begin
            // ignore everything until end of response
        end else if (!in_body_reg) begin
            if (c == CH_LF) begin
                if (hdr_empty_reg) in_body_next = 1'b1;
                else               hdr_empty_next = 1'b1;
            end else if (c != CH_CR) begin
                hdr_empty_next = 1'b0;
            end
        end else if (in_tag_reg) begin
            if (c == CH_GT) in_tag_next = 1'b0;
        end else if (c == CH_LT) begin
            in_tag_next = 1'b1;
        end else if (c == CH_LF) begin
            emit            = 1'b1;
            out_eol_next    = 1'b1;
            lines_done_next = lines_done_reg + LIMIT_W'(1);
            column_next     = '0;
        end else if (c >= CH_PRINT_LO && c < CH_PRINT_END && column_reg < eff_width) begin
            emit          = 1'b1;
            out_char_next = c[6:0];
            column_next   = column_reg + WIDTH_W'(1);
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            line_width_reg <= LINE_WIDTH_RESET;
            line_limit_reg <= LINE_LIMIT_RESET;
        end else if (cfg_valid && cfg_ready) begin
            unique case (reg_index_t'(cfg_index))
                REG_LINE_WIDTH: line_width_reg <= cfg_data[WIDTH_W-1:0];
                REG_LINE_LIMIT: line_limit_reg <= cfg_data[LIMIT_W-1:0];
                default: ;
            endcase
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            in_body_reg    <= 1'b0;
            hdr_empty_reg  <= 1'b1;
            in_tag_reg     <= 1'b0;
            lines_done_reg <= '0;
            column_reg     <= '0;
            out_valid_reg  <= 1'b0;
        end else begin
            if (s_accept) begin
                in_body_reg    <= in_body_next;
                hdr_empty_reg  <= hdr_empty_next;
                in_tag_reg     <= in_tag_next;
                lines_done_reg <= lines_done_next;
                column_reg     <= column_next;
            end
            if (s_accept && emit) begin
                out_valid_reg <= 1'b1;
            end else if (m_tready) begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    // result payload, no reset needed
    always_ff @(posedge aclk) begin
        if (s_accept && emit) begin
            out_eol_reg  <= out_eol_next;
            out_char_reg <= out_char_next;
            out_line_reg <= out_line_next;
            out_col_reg  <= out_col_next;
        end
    end

    assign m_tvalid = out_valid_reg;
    assign m_tuser  = out_eol_reg;
    assign m_tdata  = {7'd0, out_col_reg, out_line_reg, out_char_reg};

    // line counter never passes MAX_LINE_LIMIT
    a_lines_bound: assert property (@(posedge aclk) disable iff (!aresetn)
        lines_done_reg <= LIMIT_W'(MAX_LINE_LIMIT))
        else $error("lines_done above MAX_LINE_LIMIT");

    // column never passes MAX_LINE_WIDTH
    a_col_bound: assert property (@(posedge aclk) disable iff (!aresetn)
        column_reg <= WIDTH_W'(MAX_LINE_WIDTH))
        else $error("column above MAX_LINE_WIDTH");

    // end-of-line items carry no character
    a_eol_char: assert property (@(posedge aclk) disable iff (!aresetn)
        (out_valid_reg && out_eol_reg) |-> (out_char_reg == 7'd0))
        else $error("end-of-line item with nonzero character");

    // end of response restarts parsing
    a_end_clears: assert property (@(posedge aclk) disable iff (!aresetn)
        (s_accept && item_kind_t'(s_tuser) == KIND_END) |=>
        (!in_body_reg && !in_tag_reg && hdr_empty_reg &&
         lines_done_reg == '0 && column_reg == '0))
        else $error("state not cleared after end of response");

endmodule

// ===== dv/tb.sv =====
// tb: self-checking testbench for http_body_text_extractor.
// Depends on hbte_pkg and the extractor RTL; needs no other files.
`timescale 1ns / 1ps

module tb;
    import hbte_pkg::*;

    // The output register delays each result; SETTLE_CYCLES spare cycles
    // cover bytes that are still in flight but produce no text.
    localparam int SETTLE_CYCLES = 4;
    localparam int RANDOM_ITEMS  = 400;
    localparam int NUM_PHASES    = 4;

    typedef struct packed {
        logic        eol;
        logic [6:0]  ch;
        logic [6:0]  line;
        logic [10:0] col;
    } text_item_t;

    // Clock, reset and DUT-facing signals; the ones driven here are known from time zero.
    logic               aclk      = 1'b0;
    logic               aresetn   = 1'b0;
    logic               cfg_valid = 1'b0;
    logic               cfg_ready;
    logic [0:0]         cfg_index = '0;
    logic [CFG_W-1:0]   cfg_data  = '0;
    logic               s_tvalid  = 1'b0;
    logic               s_tready;
    logic [7:0]         s_tdata   = '0;   // [7:0] data_byte
    logic [0:0]         s_tuser   = '0;   // [0] kind
    logic               m_tvalid;
    logic               m_tready  = 1'b0;
    logic [31:0]        m_tdata;          // [6:0] text_char, [13:7] line_number,
                                          // [24:14] column, [31:25] zero
    logic [0:0]         m_tuser;          // [0] end_of_line

    // Idle probabilities in percent, changed per phase.
    int send_idle_pct  = 0;
    int recv_stall_pct = 0;

    int items_sent = 0;
    int mismatches = 0;

    // Text items predicted but not yet seen on the result stream.
    text_item_t pending_text[$];

    // Predictor copy of the registers and parse state.
    logic [WIDTH_W-1:0] width_reg   = LINE_WIDTH_RESET;
    logic [LIMIT_W-1:0] limit_reg   = LINE_LIMIT_RESET;
    logic               in_body     = 1'b0;
    logic               hdr_empty   = 1'b1;
    logic               in_tag      = 1'b0;
    int                 lines_done  = 0;
    int                 col_now     = 0;

    http_body_text_extractor dut (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .cfg_valid (cfg_valid),
        .cfg_ready (cfg_ready),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .s_tvalid  (s_tvalid),
        .s_tready  (s_tready),
        .s_tdata   (s_tdata),
        .s_tuser   (s_tuser),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata),
        .m_tuser   (m_tuser)
    );

    always #1 aclk = ~aclk;

    // ------------------------------------------------------------------
    // Predictor: advance the parse state by one accepted item and queue
    // the text item it produces, if any.
    // ------------------------------------------------------------------
    task automatic parse_item(input item_kind_t kind, input logic [7:0] b);
        text_item_t t;
        int         w;
        int         lim;
        w   = (width_reg > MAX_LINE_WIDTH) ? MAX_LINE_WIDTH : int'(width_reg);
        lim = (limit_reg > MAX_LINE_LIMIT) ? MAX_LINE_LIMIT : int'(limit_reg);
        if (kind == KIND_END) begin
            // flush a partial line unless the limit is already reached
            if (col_now > 0 && lines_done < lim) begin
                t = '{eol: 1'b1, ch: 7'd0, line: lines_done[6:0], col: col_now[10:0]};
                pending_text.push_back(t);
            end
            in_body    = 1'b0;
            hdr_empty  = 1'b1;
            in_tag     = 1'b0;
            lines_done = 0;
            col_now    = 0;
        end else if (lines_done >= lim) begin
            // line limit reached: everything ignored until end of response
        end else if (!in_body) begin
            // header: CR alone keeps the line empty; empty line opens the body
            if (b == CH_LF) begin
                if (hdr_empty)
                    in_body = 1'b1;
                else
                    hdr_empty = 1'b1;
            end else if (b != CH_CR) begin
                hdr_empty = 1'b0;
            end
        end else if (in_tag) begin
            if (b == CH_GT)
                in_tag = 1'b0;
        end else if (b == CH_LT) begin
            in_tag = 1'b1;
        end else if (b == CH_LF) begin
            t = '{eol: 1'b1, ch: 7'd0, line: lines_done[6:0], col: col_now[10:0]};
            pending_text.push_back(t);
            lines_done++;
            col_now = 0;
        end else if (b >= CH_PRINT_LO && b < CH_PRINT_END && col_now < w) begin
            t = '{eol: 1'b0, ch: b[6:0], line: lines_done[6:0], col: col_now[10:0]};
            pending_text.push_back(t);
            col_now++;
        end
    endtask

    task automatic check_field(input string name, input int want, input int got);
        if (want != got) begin
            $error("%s mismatch: expected %0d, actual %0d", name, want, got);
            mismatches++;
        end
    endtask

    // ------------------------------------------------------------------
    // Monitor: everything is sampled at the rising edge. The result seen
    // at an edge is compared before the item accepted at the same edge is
    // predicted, since that item cannot have produced output yet.
    // ------------------------------------------------------------------
    always @(posedge aclk) begin : monitor
        text_item_t want;
        if (aresetn) begin
            if (m_tvalid && m_tready) begin
                if (pending_text.size() == 0) begin
                    $error("unexpected result item: end_of_line %0d text_char %0d line %0d col %0d",
                           m_tuser[0], m_tdata[6:0], m_tdata[13:7], m_tdata[24:14]);
                    mismatches++;
                end else begin
                    want = pending_text.pop_front();
                    check_field("end_of_line", want.eol,  m_tuser[0]);
                    check_field("text_char",   want.ch,   m_tdata[6:0]);
                    check_field("line_number", want.line, m_tdata[13:7]);
                    check_field("column",      want.col,  m_tdata[24:14]);
                    check_field("tdata_pad",   0,         m_tdata[31:25]);
                end
            end
            if (cfg_valid && cfg_ready) begin
                case (reg_index_t'(cfg_index))
                    REG_LINE_WIDTH: width_reg = cfg_data[WIDTH_W-1:0];
                    REG_LINE_LIMIT: limit_reg = cfg_data[LIMIT_W-1:0];
                    default: ;
                endcase
            end
            if (s_tvalid && s_tready)
                parse_item(item_kind_t'(s_tuser), s_tdata);
        end
    end

    // Receiver back-pressure, re-rolled every cycle.
    always @(negedge aclk)
        m_tready <= ($urandom_range(99) >= recv_stall_pct);

    // ------------------------------------------------------------------
    // Drivers. Inputs change on the falling edge only; each task but write_reg leaves
    // off right after the rising edge of its handshake; write_reg also drops cfg_valid on a falling edge.
    // ------------------------------------------------------------------
    task automatic send_item(input item_kind_t kind, input logic [7:0] b);
        @(negedge aclk);
        while ($urandom_range(99) < send_idle_pct) begin
            s_tvalid <= 1'b0;
            @(negedge aclk);
        end
        s_tvalid <= 1'b1;
        s_tuser  <= kind;
        s_tdata  <= b;
        do @(posedge aclk); while (!s_tready);
        items_sent++;
    endtask

    task automatic send_byte(input logic [7:0] b);
        send_item(KIND_BYTE, b);
    endtask

    task automatic send_text(input string s);
        for (int i = 0; i < s.len(); i++)
            send_byte(s[i]);
    endtask

    task automatic end_response();
        send_item(KIND_END, 8'($urandom_range(255)));
    endtask

    // Stop sending, wait for every predicted item, then let in-flight
    // bytes settle so the block is idle.
    task automatic wait_idle();
        @(negedge aclk);
        s_tvalid <= 1'b0;
        while (pending_text.size() != 0)
            @(posedge aclk);
        repeat (SETTLE_CYCLES) @(posedge aclk);
    endtask

    task automatic write_reg(input reg_index_t idx, input int value);
        @(negedge aclk);
        cfg_valid <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= value[CFG_W-1:0];
        do @(posedge aclk); while (!cfg_ready);
        @(negedge aclk);
        cfg_valid <= 1'b0;
    endtask

    task automatic configure(input int width, input int limit);
        wait_idle();
        write_reg(REG_LINE_WIDTH, width);
        write_reg(REG_LINE_LIMIT, limit);
    endtask

    // Register picks lean on the edges: zero, tiny, reset values, the
    // clamp limits and values past them.
    function automatic int pick_width();
        case ($urandom_range(5))
            0:       return 0;
            1:       return $urandom_range(4, 1);
            2:       return $urandom_range(20, 5);
            3:       return 780;
            4:       return MAX_LINE_WIDTH;
            default: return $urandom_range(2047, 0);
        endcase
    endfunction

    function automatic int pick_limit();
        case ($urandom_range(5))
            0:       return 0;
            1:       return $urandom_range(3, 1);
            2:       return $urandom_range(10, 4);
            3:       return 70;
            4:       return $urandom_range(255, MAX_LINE_LIMIT);
            default: return $urandom_range(255, 0);
        endcase
    endfunction

    // One random response: header lines, usually an empty line, then body
    // lines mixing text, tags, CR and raw bytes, usually an end item.
    task automatic send_response();
        int n_hdr;
        int n_lines;
        int len;
        int r;
        n_hdr = $urandom_range(3);
        for (int h = 0; h < n_hdr; h++) begin
            len = $urandom_range(8, 1);
            for (int i = 0; i < len; i++) begin
                r = $urandom_range(99);
                if (r < 85)
                    send_byte(8'($urandom_range(126, 32)));
                else if (r < 93)
                    send_byte(CH_CR);
                else
                    send_byte(8'($urandom_range(255)));
            end
            if ($urandom_range(1))
                send_byte(CH_CR);
            send_byte(CH_LF);
        end
        // a broken header now and then: no empty line before the body
        if ($urandom_range(9) != 0) begin
            if ($urandom_range(1))
                send_byte(CH_CR);
            send_byte(CH_LF);
        end
        n_lines = $urandom_range(6);
        for (int l = 0; l < n_lines; l++) begin
            len = $urandom_range(14);
            for (int i = 0; i < len; i++) begin
                r = $urandom_range(99);
                if (r < 60) begin
                    send_byte(8'($urandom_range(126, 32)));
                end else if (r < 70) begin
                    // tag with arbitrary contents, LF included
                    send_byte(CH_LT);
                    repeat ($urandom_range(4)) send_byte(8'($urandom_range(255)));
                    send_byte(CH_GT);
                end else if (r < 78) begin
                    send_byte(CH_CR);
                end else begin
                    send_byte(8'($urandom_range(255)));
                end
            end
            case ($urandom_range(3))
                0:       ;                 // line left open
                1:       begin send_byte(CH_CR); send_byte(CH_LF); end
                default: send_byte(CH_LF);
            endcase
        end
        if ($urandom_range(9) != 0)
            end_response();
    endtask

    // ------------------------------------------------------------------
    // Tests
    // ------------------------------------------------------------------

    // Reset register values; header skip, printable extremes, dropped
    // bytes, tag holding an LF, CR in body, flush and empty flush.
    task automatic test_basic_parsing();
        configure(LINE_WIDTH_RESET, LINE_LIMIT_RESET);
        send_text("H");
        send_byte(CH_CR);
        send_text("\n");
        send_byte(CH_CR);                  // CR-only line still counts as empty
        send_text("\n");
        send_text(" ~");
        send_byte(8'h7F);
        send_byte(8'h1F);
        send_byte(8'hFF);
        send_byte(8'h00);
        send_text("<x\n>");
        send_byte(CH_CR);
        send_text("a\n");
        send_text("b");
        end_response();                    // flushes the partial line
        end_response();                    // nothing left to flush
    endtask

    // Width zero, width one, limit zero, limit one with bytes past it.
    task automatic test_register_extremes();
        configure(0, LINE_LIMIT_RESET);
        send_text("\nab\n");
        end_response();
        configure(1, 0);
        send_text("\na\n");
        end_response();
        configure(1, 1);
        send_text("\nab\nc\n");
        end_response();
    endtask

    // Registers above their clamp values: one line longer than the
    // widest allowed, then more lines than the deepest limit.
    task automatic test_clamped_registers();
        configure(2047, 255);
        send_text("\n");
        repeat (MAX_LINE_WIDTH + 6) send_byte(8'($urandom_range(126, 32)));
        send_byte(CH_LF);
        for (int l = 0; l < MAX_LINE_LIMIT + 2; l++) begin
            if ($urandom_range(1))
                send_byte(8'($urandom_range(126, 32)));
            send_byte(CH_LF);
        end
        end_response();
    endtask

    // Random responses under each idle profile, with register changes
    // between responses and in mid-line.
    task automatic test_random_traffic();
        int start;
        int r;
        for (int phase = 0; phase < NUM_PHASES; phase++) begin
            case (phase)
                0:       begin send_idle_pct = 0;  recv_stall_pct = 0;  end
                1:       begin send_idle_pct = 47; recv_stall_pct = 0;  end
                2:       begin send_idle_pct = 0;  recv_stall_pct = 47; end
                default: begin send_idle_pct = 6;  recv_stall_pct = 6;  end
            endcase
            configure(pick_width(), pick_limit());
            start = items_sent;
            while (items_sent - start < RANDOM_ITEMS / NUM_PHASES) begin
                r = $urandom_range(99);
                if (r < 4) begin
                    // drain fully, then retune in the middle of a response
                    wait_idle();
                    if ($urandom_range(1))
                        write_reg(REG_LINE_WIDTH, pick_width());
                    else
                        write_reg(REG_LINE_LIMIT, pick_limit());
                end else if (r < 14) begin
                    repeat ($urandom_range(5, 1))
                        send_item(item_kind_t'($urandom_range(1)), 8'($urandom_range(255)));
                end else begin
                    send_response();
                end
            end
        end
    endtask

    initial begin
        repeat (6) @(posedge aclk);
        @(negedge aclk);
        aresetn <= 1'b1;

        test_basic_parsing();
        send_idle_pct  = 6;
        recv_stall_pct = 6;
        test_register_extremes();
        send_idle_pct  = 0;
        recv_stall_pct = 0;
        test_clamped_registers();
        test_random_traffic();

        // everything sent: drain what is predicted, then settle
        wait_idle();
        if (mismatches == 0)
            $display("TB_OK");
        else
            $display("TB_ERROR");
        $finish;
    end

    // Watchdog far beyond the slowest legal run.
    initial begin
        #400000;
        $display("TB_ERROR");
        $finish;
    end

endmodule
